// ===== rtl/tsap_pkg.sv =====
// ----------------------------------------------------------------------------
// tsap_pkg
// Shared constants, types and the angle table of the tone symbol amplitude/phase block.
// ----------------------------------------------------------------------------
package tsap_pkg;

	// Frame and sample geometry.
	localparam int SYMBOLS      = 79;
	localparam int MAX_BLOCK    = 4096;
	localparam int SAMPLE_BITS  = 16;
	localparam int CORDIC_STEPS = 14;

	// Datapath widths.
	localparam int LEN_W  = 13;
	localparam int CNT_W  = 12;
	localparam int SYM_W  = 7;
	localparam int ACC_W  = 48;
	localparam int ROT_W  = 18;
	localparam int VEC_W  = 51;
	localparam int VZ_W   = 17;
	localparam int ITER_W = 4;
	localparam int REM_W  = 37;
	localparam int OUT_W  = 16;
	localparam int PROD_W = SAMPLE_BITS + 16;

	// Oscillator start value and magnitude gain correction.
	localparam logic signed [ROT_W-1:0] ROT_X0   = 18'sd19898;
	localparam logic [15:0]             MAG_GAIN = 16'd39797;

	// Register map and reset values.
	typedef enum logic [1:0] {
		REG_BASE_STEP = 2'd0,
		REG_TONE_STEP = 2'd1,
		REG_BLOCK_LEN = 2'd2
	} reg_idx_t;

	localparam logic [31:0]      BASE_STEP_RST = 32'd0;
	localparam logic [31:0]      TONE_STEP_RST = 32'd2236962;
	localparam logic [LEN_W-1:0] BLOCK_LEN_RST = 13'd1920;

	typedef struct packed {
		logic [31:0]      base_step;
		logic [31:0]      tone_step;
		logic [LEN_W-1:0] block_len;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              accept;
		logic              rot_step;
		logic              mul;
		logic              acc;
		logic              vec_init;
		logic              vec_step;
		logic              mag_lo;
		logic              mag_hi;
		logic              mag_sum;
		logic              mag_rnd;
		logic              sat_chk;
		logic              div_step;
		logic              out_load;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic end_sym;
		logic out_free;
	} status_t;

	// CORDIC angle table, 65536 units per turn.
	function automatic logic [13:0] atan_lut(input logic [ITER_W-1:0] i);
		logic [13:0] a;
		case (i)
			4'd0:    a = 14'd8192;
			4'd1:    a = 14'd4836;
			4'd2:    a = 14'd2555;
			4'd3:    a = 14'd1297;
			4'd4:    a = 14'd651;
			4'd5:    a = 14'd326;
			4'd6:    a = 14'd163;
			4'd7:    a = 14'd81;
			4'd8:    a = 14'd41;
			4'd9:    a = 14'd20;
			4'd10:   a = 14'd10;
			4'd11:   a = 14'd5;
			4'd12:   a = 14'd3;
			4'd13:   a = 14'd1;
			default: a = 14'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/tsap_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsap_ctrl
// Sequencer: steps the oscillator CORDIC per sample and, at the end of a
// symbol, the vectoring CORDIC, magnitude scaling and the quotient loop.
// ----------------------------------------------------------------------------
module tsap_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tsap_pkg::status_t  status,
	output tsap_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROT, ST_MUL, ST_ACC, ST_VINIT, ST_VEC, ST_MLO, ST_MHI,
		ST_MSUM, ST_MRND, ST_SAT, ST_DIV, ST_DONE
	} state_t;

	localparam logic [tsap_pkg::ITER_W-1:0] LAST_STEP =
		tsap_pkg::ITER_W'(tsap_pkg::CORDIC_STEPS - 1);
	localparam logic [tsap_pkg::ITER_W-1:0] LAST_DIV = tsap_pkg::ITER_W'(15);

	state_t                      state_q, state_d;
	logic [tsap_pkg::ITER_W-1:0] iter_q, iter_d;
	logic                        in_stall_q;
	logic                        accept;

	assign accept   = in_valid & ~in_stall_q;
	assign in_stall = in_stall_q;

	// Next state and iteration count.
	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		unique case (state_q)
			ST_IDLE: begin
				iter_d = '0;
				if (accept) begin
					state_d = ST_ROT;
				end
			end
			ST_ROT: begin
				iter_d = iter_q + 1'b1;
				if (iter_q == LAST_STEP) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = status.end_sym ? ST_VINIT : ST_IDLE;
			ST_VINIT: begin
				iter_d  = '0;
				state_d = ST_VEC;
			end
			ST_VEC: begin
				iter_d = iter_q + 1'b1;
				if (iter_q == LAST_STEP) begin
					state_d = ST_MLO;
				end
			end
			ST_MLO:  state_d = ST_MHI;
			ST_MHI:  state_d = ST_MSUM;
			ST_MSUM: state_d = ST_MRND;
			ST_MRND: state_d = ST_SAT;
			ST_SAT: begin
				iter_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				iter_d = iter_q + 1'b1;
				if (iter_q == LAST_DIV) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and the registered stall output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iter_q     <= '0;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			iter_q     <= iter_d;
			in_stall_q <= (state_d != ST_IDLE);
		end
	end

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.iter     = iter_q;
		cmd.accept   = (state_q == ST_IDLE) & accept;
		cmd.rot_step = (state_q == ST_ROT);
		cmd.mul      = (state_q == ST_MUL);
		cmd.acc      = (state_q == ST_ACC);
		cmd.vec_init = (state_q == ST_VINIT);
		cmd.vec_step = (state_q == ST_VEC);
		cmd.mag_lo   = (state_q == ST_MLO);
		cmd.mag_hi   = (state_q == ST_MHI);
		cmd.mag_sum  = (state_q == ST_MSUM);
		cmd.mag_rnd  = (state_q == ST_MRND);
		cmd.sat_chk  = (state_q == ST_SAT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) & status.out_free;
	end

endmodule

// ===== rtl/tsap_dp.sv =====
// ----------------------------------------------------------------------------
// tsap_dp
// Datapath: oscillator phase, rotation CORDIC, correlation accumulators,
// vectoring CORDIC, magnitude scaling, quotient loop and result register.
// ----------------------------------------------------------------------------
module tsap_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsap_pkg::cfg_t                      cfg,
	input  tsap_pkg::cmd_t                      cmd,
	output tsap_pkg::status_t                   status,
	input  logic signed [tsap_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [2:0]                          tone,
	input  logic                                in_range,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tsap_pkg::OUT_W-1:0]          amplitude,
	output logic signed [tsap_pkg::OUT_W-1:0]   phase,
	output logic [tsap_pkg::SYM_W-1:0]          symbol_index,
	output logic                                last_symbol
);

	localparam int LW = tsap_pkg::LEN_W;
	localparam int RW = tsap_pkg::ROT_W;
	localparam int VW = tsap_pkg::VEC_W;
	localparam int ZW = tsap_pkg::VZ_W;
	localparam int AW = tsap_pkg::ACC_W;
	localparam int QW = tsap_pkg::REM_W;

	// Symbol state.
	logic [31:0]                 phase_q, step_q;
	logic [tsap_pkg::CNT_W-1:0]  scount_q;
	logic signed [AW-1:0]        acc_re_q, acc_im_q;
	logic [tsap_pkg::SYM_W-1:0]  sym_q;
	logic                        out_valid_q;

	// Work registers.
	logic signed [tsap_pkg::SAMPLE_BITS-1:0] smp_q;
	logic                        rng_q, end_q, flip_q, zero_q, sat_q;
	logic signed [RW-1:0]        rx_q, ry_q, rz_q;
	logic signed [tsap_pkg::PROD_W-1:0] pre_q, pim_q;
	logic signed [VW-1:0]        vx_q, vy_q;
	logic signed [ZW-1:0]        vz_q;
	logic [40:0]                 plo_q, phi_q;
	logic [65:0]                 num_q;
	logic [QW-1:0]               rem_q;
	logic [15:0]                 quo_q;
	logic [tsap_pkg::OUT_W-1:0]  amp_q;
	logic signed [tsap_pkg::OUT_W-1:0] ang_q;
	logic [tsap_pkg::SYM_W-1:0]  idx_q;
	logic                        last_q;

	// Effective block length.
	logic [LW-1:0] len;
	always_comb begin
		if (cfg.block_len == '0) begin
			len = LW'(1);
		end else if (cfg.block_len > LW'(tsap_pkg::MAX_BLOCK)) begin
			len = LW'(tsap_pkg::MAX_BLOCK);
		end else begin
			len = cfg.block_len;
		end
	end

	// Phase step and phase for the accepted sample.
	logic        first;
	logic [31:0] tone_mul, new_step, phase_use;
	logic        end_now;
	assign first     = (scount_q == '0);
	assign tone_mul  = (tone[0] ? cfg.tone_step : 32'd0)
	                 + (tone[1] ? {cfg.tone_step[30:0], 1'b0} : 32'd0)
	                 + (tone[2] ? {cfg.tone_step[29:0], 2'b0} : 32'd0);
	assign new_step  = first ? (cfg.base_step + tone_mul) : step_q;
	assign phase_use = first ? 32'd0 : phase_q;
	assign end_now   = ({1'b0, scount_q} + LW'(1)) >= len;

	// Fold the angle into the right half plane for the rotation CORDIC.
	logic signed [15:0]   zp;
	logic signed [RW-1:0] z_init;
	logic                 flip_init;
	always_comb begin
		zp        = phase_use[31:16];
		z_init    = RW'(zp);
		flip_init = 1'b0;
		if (zp > 16'sd16384) begin
			z_init    = RW'(zp) - RW'(32768);
			flip_init = 1'b1;
		end else if (zp < -16'sd16384) begin
			z_init    = RW'(zp) + RW'(32768);
			flip_init = 1'b1;
		end
	end

	// Oscillator outputs, sign restored and clamped to Q1.15.
	logic signed [RW-1:0] cx, sy;
	logic signed [15:0]   cos_v, sin_v;
	always_comb begin
		cx = flip_q ? -rx_q : rx_q;
		sy = flip_q ? -ry_q : ry_q;
		if (cx > RW'(32767)) cos_v = 16'sd32767;
		else if (cx < -RW'(32767)) cos_v = -16'sd32767;
		else cos_v = cx[15:0];
		if (sy > RW'(32767)) sin_v = 16'sd32767;
		else if (sy < -RW'(32767)) sin_v = -16'sd32767;
		else sin_v = sy[15:0];
	end

	// Magnitude operand and the quotient trial divisor.
	logic [49:0]   xm;
	logic [QW-1:0] div_d;
	logic          div_ge;
	assign xm     = vx_q[VW-1] ? 50'd0 : vx_q[49:0];
	assign div_d  = QW'({len, 15'd0}) >> cmd.iter;
	assign div_ge = rem_q >= div_d;

	// Result fields.
	logic [tsap_pkg::SYM_W-1:0] idx;
	assign idx = (sym_q >= tsap_pkg::SYM_W'(tsap_pkg::SYMBOLS)) ? '0 : sym_q;

	// Symbol state, accumulators and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			step_q      <= '0;
			scount_q    <= '0;
			acc_re_q    <= '0;
			acc_im_q    <= '0;
			sym_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				step_q   <= new_step;
				phase_q  <= phase_use + new_step;
				scount_q <= end_now ? '0 : scount_q + 1'b1;
			end
			if (cmd.acc && rng_q) begin
				acc_re_q <= acc_re_q + AW'(pre_q);
				acc_im_q <= acc_im_q - AW'(pim_q);
			end
			if (cmd.vec_init) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end
			if (cmd.out_load) begin
				sym_q <= ((idx + 1'b1) >= tsap_pkg::SYM_W'(tsap_pkg::SYMBOLS)) ?
				         '0 : idx + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// CORDIC iterations, products, scaling and quotient loop.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			smp_q  <= sample;
			rng_q  <= in_range;
			end_q  <= end_now;
			rx_q   <= tsap_pkg::ROT_X0;
			ry_q   <= '0;
			rz_q   <= z_init;
			flip_q <= flip_init;
		end
		if (cmd.rot_step) begin
			if (!rz_q[RW-1]) begin
				rx_q <= rx_q - (ry_q >>> cmd.iter);
				ry_q <= ry_q + (rx_q >>> cmd.iter);
				rz_q <= rz_q - RW'(tsap_pkg::atan_lut(cmd.iter));
			end else begin
				rx_q <= rx_q + (ry_q >>> cmd.iter);
				ry_q <= ry_q - (rx_q >>> cmd.iter);
				rz_q <= rz_q + RW'(tsap_pkg::atan_lut(cmd.iter));
			end
		end
		if (cmd.mul) begin
			pre_q <= smp_q * cos_v;
			pim_q <= smp_q * sin_v;
		end
		if (cmd.vec_init) begin
			zero_q <= (acc_re_q == '0) && (acc_im_q == '0);
			if (acc_re_q[AW-1]) begin
				vx_q <= -VW'(acc_re_q);
				vy_q <= -VW'(acc_im_q);
				vz_q <= ZW'(32768);
			end else begin
				vx_q <= VW'(acc_re_q);
				vy_q <= VW'(acc_im_q);
				vz_q <= '0;
			end
		end
		if (cmd.vec_step) begin
			if (vy_q[VW-1]) begin
				vx_q <= vx_q - (vy_q >>> cmd.iter);
				vy_q <= vy_q + (vx_q >>> cmd.iter);
				vz_q <= vz_q - ZW'(tsap_pkg::atan_lut(cmd.iter));
			end else begin
				vx_q <= vx_q + (vy_q >>> cmd.iter);
				vy_q <= vy_q - (vx_q >>> cmd.iter);
				vz_q <= vz_q + ZW'(tsap_pkg::atan_lut(cmd.iter));
			end
		end
		if (cmd.mag_lo) begin
			plo_q <= 41'(xm[24:0]) * 41'(tsap_pkg::MAG_GAIN);
		end
		if (cmd.mag_hi) begin
			phi_q <= 41'(xm[49:25]) * 41'(tsap_pkg::MAG_GAIN);
		end
		if (cmd.mag_sum) begin
			num_q <= {phi_q[40:0], 25'd0} + 66'(plo_q);
		end
		// Rounded scale by 2^-30; the divide by the length follows.
		if (cmd.mag_rnd) begin
			rem_q <= QW'((67'(num_q) + (67'(len) << 29)) >> 30);
		end
		if (cmd.sat_chk) begin
			sat_q <= rem_q >= QW'({len, 16'd0});
		end
		if (cmd.div_step) begin
			if (div_ge) begin
				rem_q <= rem_q - div_d;
			end
			quo_q <= {quo_q[14:0], div_ge};
		end
		if (cmd.out_load) begin
			amp_q  <= zero_q ? '0 : (sat_q ? 16'hFFFF : quo_q);
			ang_q  <= zero_q ? '0 : vz_q[15:0];
			idx_q  <= idx;
			last_q <= (idx == tsap_pkg::SYM_W'(tsap_pkg::SYMBOLS - 1));
		end
	end

	assign status.end_sym  = end_q;
	assign status.out_free = ~out_valid_q | ~out_stall;

	assign out_valid    = out_valid_q;
	assign amplitude    = amp_q;
	assign phase        = ang_q;
	assign symbol_index = idx_q;
	assign last_symbol  = last_q;

endmodule

// ===== rtl/tone_symbol_amplitude_phase_top.sv =====
// ----------------------------------------------------------------------------
// tone_symbol_amplitude_phase_top
// Single-bin correlator: amplitude and phase of the symbol tone per symbol.
// ----------------------------------------------------------------------------
//  Channel   Signals                                          Direction
//  input     in_valid, in_stall, sample, tone, in_range       in (stall out)
//  output    out_valid, out_stall, amplitude, phase,          out (stall in)
//            symbol_index, last_symbol
//  config    psel, penable, pwrite, paddr, pwdata, prdata,    APB slave
//            pready
//
//  A sample takes an accept, 14 rotation CORDIC steps, a multiply and
//  an accumulate. The last sample of a symbol adds a vectoring set-up,
//  14 vectoring CORDIC steps, scaling, a saturation check, 16 quotient steps.
//  A finished result waits in the output register while the next sample is
//  taken; a second result waits until the first one has been transferred.
//  Reset clears the oscillator, accumulators and counters; no clearing pass.
// ----------------------------------------------------------------------------
module tone_symbol_amplitude_phase_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [tsap_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic [2:0]                               tone,
	input  logic                                     in_range,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [tsap_pkg::OUT_W-1:0]               amplitude,
	output logic signed [tsap_pkg::OUT_W-1:0]        phase,
	output logic [tsap_pkg::SYM_W-1:0]               symbol_index,
	output logic                                     last_symbol,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [3:0]                               paddr,
	input  logic [31:0]                              pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	tsap_pkg::cfg_t     cfg_q;
	tsap_pkg::cmd_t     cmd;
	tsap_pkg::status_t  status;
	tsap_pkg::reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = tsap_pkg::reg_idx_t'(paddr[3:2]);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_step <= tsap_pkg::BASE_STEP_RST;
			cfg_q.tone_step <= tsap_pkg::TONE_STEP_RST;
			cfg_q.block_len <= tsap_pkg::BLOCK_LEN_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				tsap_pkg::REG_BASE_STEP: cfg_q.base_step <= pwdata;
				tsap_pkg::REG_TONE_STEP: cfg_q.tone_step <= pwdata;
				tsap_pkg::REG_BLOCK_LEN: cfg_q.block_len <= pwdata[tsap_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			tsap_pkg::REG_BASE_STEP: prdata = cfg_q.base_step;
			tsap_pkg::REG_TONE_STEP: prdata = cfg_q.tone_step;
			tsap_pkg::REG_BLOCK_LEN: prdata = 32'(cfg_q.block_len);
			default:                 prdata = '0;
		endcase
	end

	tsap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tsap_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.tone         (tone),
		.in_range     (in_range),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.amplitude    (amplitude),
		.phase        (phase),
		.symbol_index (symbol_index),
		.last_symbol  (last_symbol)
	);

endmodule

// ===== rtl/tsap_checker.sv =====
// ----------------------------------------------------------------------------
// tsap_checker
// Port-level checks of the correlator, bound to the top level.
// ----------------------------------------------------------------------------
module tsap_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [tsap_pkg::OUT_W-1:0]        amplitude,
	input logic [tsap_pkg::SYM_W-1:0]        symbol_index,
	input logic                              last_symbol
);

	// A sample transfer keeps the input stalled while it is worked on.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a sample transfer");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(amplitude)
		&& $stable(symbol_index))
		else $error("stalled result changed");

	// The frame flag marks only the final symbol.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_symbol == (symbol_index ==
		tsap_pkg::SYM_W'(tsap_pkg::SYMBOLS - 1))))
		else $error("last_symbol does not match symbol_index");

	// Symbol indexes stay inside the frame.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> symbol_index < tsap_pkg::SYM_W'(tsap_pkg::SYMBOLS))
		else $error("symbol index beyond frame");

endmodule

bind tone_symbol_amplitude_phase_top tsap_checker u_tsap_checker (.*);
